// ----- hw/rtl/bfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared widths, codes and types of the best-fit segment allocator.
// ----------------------------------------------------------------------------
package bfsa_pkg;

    localparam int ADDR_W  = 20;
    localparam int LEN_W   = 21;
    localparam int SIZE_W  = 20;
    localparam int CFG_W   = 21;
    localparam int ACT_W   = 2;
    localparam int ST_W    = 2;
    localparam int CIDX_W  = 2;

    localparam int DEF_ENTRIES = 64;

    localparam logic [LEN_W-1:0] GROW_RESET = 21'd2000;
    localparam logic [LEN_W-1:0] POOL_RESET = 21'd1048576;
    localparam logic [LEN_W-1:0] ADDR_SPAN  = 21'h100000;
    localparam logic [LEN_W-1:0] GROW_MAX   = 21'h1FFFF8;

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REALLOC = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RSVD    = 2'd3;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_MEM   = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_ADDR = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_GROW_CHUNK = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_POOL_LIMIT = 2'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] seg_start;
        logic [LEN_W-1:0]  seg_len;
        logic              seg_res;
    } t_seg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_I,
        S_EV_I,
        S_FIND_NB,
        S_EV_NB,
        S_FIT,
        S_EV_FIT,
        S_MOD,
        S_DROP,
        S_NEXT,
        S_DONE
    } t_state;

endpackage

// ----- hw/rtl/bfsa_cell.sv -----
// ----------------------------------------------------------------------------
// bfsa_cell
// One segment entry of the ring; takes its neighbor's entry on each shift.
// ----------------------------------------------------------------------------
module bfsa_cell import bfsa_pkg::*; (
    input  logic i_clk,
    input  logic i_shift,
    input  t_seg i_seg,
    output t_seg o_seg
);

    t_seg r_seg;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_seg <= i_seg;
        end
    end

    assign o_seg = r_seg;

endmodule

// ----- hw/rtl/best_fit_segment_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_unit
// Each table pass rotates the cell ring once through all TABLE_ENTRIES cells.
// Busy is held across whole ring passes: allocate makes a fit and a write pass,
// free adds find, neighbor and drop passes, and a moving reallocate does both;
// one request at a time.
// The result strobe o_done lasts one cycle; the receiver cannot stall.
// Synchronous active-low reset empties the table and resets state, heap top and config.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator_unit import bfsa_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [ADDR_W-1:0] i_block_address,
    input  logic [SIZE_W-1:0] i_request_size,
    output logic              o_done,
    output logic [ADDR_W-1:0] o_result_address,
    output logic [ST_W-1:0]   o_status,
    output logic              o_moved,
    output logic [LEN_W-1:0]  o_old_length,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_J = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W:0]   ENT_C  = (CNT_W + 1)'(TABLE_ENTRIES);

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_heap_top, n_heap_top;
    logic [LEN_W-1:0] r_grow, n_grow;
    logic [LEN_W-1:0] r_pool, n_pool;

    logic [ACT_W-1:0]  r_act, n_act;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [LEN_W-1:0]  r_rsize, n_rsize;

    logic              r_fi, n_fi, r_ri, n_ri;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [ADDR_W-1:0] r_si, n_si;
    logic [LEN_W-1:0]  r_li, n_li;
    logic              r_fn, n_fn, r_rn, n_rn;
    logic [IDX_W-1:0]  r_n, n_n;
    logic [LEN_W-1:0]  r_ln, n_ln;
    logic              r_fp, n_fp, r_rp, n_rp;
    logic [IDX_W-1:0]  r_p, n_p;
    logic [ADDR_W-1:0] r_sp, n_sp;
    logic [LEN_W-1:0]  r_lp, n_lp;
    logic              r_fb, n_fb;
    logic [IDX_W-1:0]  r_b, n_b;
    logic [ADDR_W-1:0] r_sb, n_sb;
    logic [LEN_W-1:0]  r_lb, n_lb;
    logic [LEN_W-1:0]  r_slk, n_slk;

    logic              r_wa_v, n_wa_v, r_wb_v, n_wb_v;
    logic [IDX_W-1:0]  r_wa_i, n_wa_i, r_wb_i, n_wb_i;
    t_seg              r_wa, n_wa, r_wb, n_wb;
    logic              r_da_v, n_da_v, r_db_v, n_db_v;
    logic [IDX_W-1:0]  r_da, n_da, r_db, n_db;
    logic              r_ap_v, n_ap_v;
    t_seg              r_ap, n_ap;
    logic              r_moving, n_moving, r_releasing, n_releasing;

    logic [ST_W-1:0]   r_st, n_st;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic              r_moved, n_moved;
    logic [LEN_W-1:0]  r_old_len, n_old_len;

    t_seg w_cell_q [TABLE_ENTRIES];
    t_seg w_cell_d [TABLE_ENTRIES];
    t_seg w_head, w_next, w_tail;
    logic w_shift, w_hv, w_last;

    logic [LEN_W-1:0] w_end_i, w_head_end, w_slack, w_grow_amt, w_limit, w_newli;
    logic [LEN_W:0]   w_top_sum, w_sum_l, w_cfg_g;
    logic [CNT_W:0]   w_cnt_f, w_cnt_g;
    logic             w_need_f, w_split_g, w_inplace, w_mn, w_mp;

    // ring of cells
    genvar k;
    generate
        for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
            if (k == TABLE_ENTRIES - 1) begin : g_tail
                assign w_cell_d[k] = w_tail;
            end else begin : g_mid
                assign w_cell_d[k] = w_cell_q[k+1];
            end
            bfsa_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_seg   (w_cell_d[k]),
                .o_seg   (w_cell_q[k])
            );
        end
    endgenerate

    assign w_head = w_cell_q[0];
    assign w_next = w_cell_q[1];
    assign w_hv   = CNT_W'(r_j) < r_count;
    assign w_last = (r_j == LAST_J);
    assign w_shift = (r_state == S_FIND_I) || (r_state == S_FIND_NB) || (r_state == S_FIT)
                  || (r_state == S_MOD) || (r_state == S_DROP);

    always_comb begin
        w_tail = w_head;
        case (r_state)
            S_MOD: begin
                if (r_wa_v && r_j == r_wa_i) begin
                    w_tail = r_wa;
                end else if (r_wb_v && r_j == r_wb_i) begin
                    w_tail = r_wb;
                end
            end
            S_DROP: begin
                if (r_j >= r_da) begin
                    w_tail = w_next;
                end
            end
            default: w_tail = w_head;
        endcase
    end

    assign w_end_i    = {1'b0, r_si} + r_li;
    assign w_head_end = {1'b0, w_head.seg_start} + w_head.seg_len;
    assign w_slack    = w_head.seg_len - r_rsize;
    assign w_need_f   = (r_slk != '0);
    assign w_grow_amt = (r_grow > r_rsize) ? r_grow : r_rsize;
    assign w_split_g  = (r_grow > r_rsize);
    assign w_limit    = (r_pool < ADDR_SPAN) ? r_pool : ADDR_SPAN;
    assign w_top_sum  = {1'b0, r_heap_top} + {1'b0, w_grow_amt};
    assign w_cnt_f    = {1'b0, r_count} + {{CNT_W{1'b0}}, w_need_f};
    assign w_cnt_g    = {1'b0, r_count} + (CNT_W + 1)'(1) + {{CNT_W{1'b0}}, w_split_g};
    assign w_sum_l    = {1'b0, r_li} + {1'b0, r_ln};
    assign w_inplace  = r_fn && !r_rn && (w_sum_l >= {1'b0, r_rsize});
    assign w_mn       = r_fn && !r_rn;
    assign w_mp       = r_fp && !r_rp;
    assign w_newli    = r_li + (w_mn ? r_ln : '0);
    assign w_cfg_g    = ({1'b0, i_cfg_data} + (LEN_W + 1)'(8)) & ~(LEN_W + 1)'(7);

    always_comb begin
        n_state = r_state;   n_j = r_j;         n_count = r_count;
        n_heap_top = r_heap_top; n_grow = r_grow; n_pool = r_pool;
        n_act = r_act;       n_addr = r_addr;   n_rsize = r_rsize;
        n_fi = r_fi; n_ri = r_ri; n_i = r_i; n_si = r_si; n_li = r_li;
        n_fn = r_fn; n_rn = r_rn; n_n = r_n; n_ln = r_ln;
        n_fp = r_fp; n_rp = r_rp; n_p = r_p; n_sp = r_sp; n_lp = r_lp;
        n_fb = r_fb; n_b = r_b; n_sb = r_sb; n_lb = r_lb; n_slk = r_slk;
        n_wa_v = r_wa_v; n_wa_i = r_wa_i; n_wa = r_wa;
        n_wb_v = r_wb_v; n_wb_i = r_wb_i; n_wb = r_wb;
        n_da_v = r_da_v; n_da = r_da; n_db_v = r_db_v; n_db = r_db;
        n_ap_v = r_ap_v; n_ap = r_ap;
        n_moving = r_moving; n_releasing = r_releasing;
        n_st = r_st; n_res_addr = r_res_addr; n_moved = r_moved; n_old_len = r_old_len;

        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_GROW_CHUNK) begin
                n_grow = (w_cfg_g > {1'b0, GROW_MAX}) ? GROW_MAX : w_cfg_g[LEN_W-1:0];
            end else if (i_cfg_index == CFG_POOL_LIMIT) begin
                n_pool = i_cfg_data;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_act = i_action;
                    n_addr = i_block_address;
                    n_rsize = {1'b0, i_request_size & ~SIZE_W'(3)} + LEN_W'(4);
                    n_st = ST_OK; n_res_addr = '0; n_moved = 1'b0; n_old_len = '0;
                    n_moving = 1'b0; n_releasing = 1'b0;
                    n_da_v = 1'b0; n_db_v = 1'b0; n_ap_v = 1'b0;
                    n_wa_v = 1'b0; n_wb_v = 1'b0;
                    n_fi = 1'b0; n_fb = 1'b0; n_j = '0;
                    case (i_action)
                        ACT_ALLOC:   n_state = S_FIT;
                        ACT_FREE:    n_state = S_FIND_I;
                        ACT_REALLOC: n_state = S_FIND_I;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_FIND_I: begin
                if (w_hv && !r_fi && w_head.seg_start == r_addr) begin
                    n_fi = 1'b1; n_i = r_j; n_si = w_head.seg_start;
                    n_li = w_head.seg_len; n_ri = w_head.seg_res;
                end
                n_j = w_last ? '0 : r_j + IDX_W'(1);
                if (w_last) n_state = S_EV_I;
            end
            S_EV_I: begin
                if (!r_fi || !r_ri) begin
                    n_st = ST_BAD_ADDR;
                    n_state = S_DONE;
                end else begin
                    n_fn = 1'b0; n_fp = 1'b0;
                    n_state = S_FIND_NB;
                end
            end
            S_FIND_NB: begin
                if (w_hv && !r_fn && {1'b0, w_head.seg_start} == w_end_i) begin
                    n_fn = 1'b1; n_n = r_j; n_ln = w_head.seg_len; n_rn = w_head.seg_res;
                end
                if (w_hv && !r_fp && w_head_end == {1'b0, r_si}) begin
                    n_fp = 1'b1; n_p = r_j; n_sp = w_head.seg_start;
                    n_lp = w_head.seg_len; n_rp = w_head.seg_res;
                end
                n_j = w_last ? '0 : r_j + IDX_W'(1);
                if (w_last) n_state = S_EV_NB;
            end
            S_EV_NB: begin
                if (r_act == ACT_REALLOC && !r_releasing) begin
                    if (w_inplace) begin
                        n_wa_v = 1'b1; n_wa_i = r_i;
                        n_wa = '{seg_start: r_si,
                                 seg_len: (w_sum_l > {1'b0, r_rsize}) ? r_rsize
                                                                       : w_sum_l[LEN_W-1:0],
                                 seg_res: 1'b1};
                        n_da_v = 1'b1; n_da = r_n;
                        n_count = r_count - CNT_W'(1);
                        n_ap_v = (w_sum_l > {1'b0, r_rsize});
                        n_ap = '{seg_start: r_si + r_rsize[ADDR_W-1:0],
                                 seg_len: w_sum_l[LEN_W-1:0] - r_rsize,
                                 seg_res: 1'b0};
                        n_res_addr = r_si;
                        n_state = S_MOD;
                    end else begin
                        n_moving = 1'b1;
                        n_fb = 1'b0;
                        n_state = S_FIT;
                    end
                end else begin
                    n_wa_v = 1'b1;
                    if (w_mp) begin
                        n_wa_i = r_p;
                        n_wa = '{seg_start: r_sp, seg_len: r_lp + w_newli, seg_res: 1'b0};
                    end else begin
                        n_wa_i = r_i;
                        n_wa = '{seg_start: r_si, seg_len: w_newli, seg_res: 1'b0};
                    end
                    if (w_mn && w_mp) begin
                        n_da_v = 1'b1; n_db_v = 1'b1;
                        n_da = (r_n > r_i) ? r_n : r_i;
                        n_db = (r_n > r_i) ? r_i : r_n;
                        n_count = r_count - CNT_W'(2);
                    end else if (w_mn) begin
                        n_da_v = 1'b1; n_da = r_n;
                        n_count = r_count - CNT_W'(1);
                    end else if (w_mp) begin
                        n_da_v = 1'b1; n_da = r_i;
                        n_count = r_count - CNT_W'(1);
                    end
                    n_state = S_MOD;
                end
            end
            S_FIT: begin
                if (w_hv && !w_head.seg_res && w_head.seg_len >= r_rsize
                    && (!r_fb || w_slack < r_slk)) begin
                    n_fb = 1'b1; n_b = r_j; n_sb = w_head.seg_start;
                    n_lb = w_head.seg_len; n_slk = w_slack;
                end
                n_j = w_last ? '0 : r_j + IDX_W'(1);
                if (w_last) n_state = S_EV_FIT;
            end
            S_EV_FIT: begin
                if (r_fb) begin
                    if (w_cnt_f > ENT_C) begin
                        n_st = ST_FULL; n_state = S_DONE;
                    end else begin
                        n_wa_v = 1'b1; n_wa_i = r_b;
                        n_wa = '{seg_start: r_sb, seg_len: w_need_f ? r_rsize : r_lb,
                                 seg_res: 1'b1};
                        n_wb_v = w_need_f; n_wb_i = r_count[IDX_W-1:0];
                        n_wb = '{seg_start: r_sb + r_rsize[ADDR_W-1:0], seg_len: r_slk,
                                 seg_res: 1'b0};
                        n_count = w_cnt_f[CNT_W-1:0];
                        n_res_addr = r_sb;
                        n_state = S_MOD;
                    end
                end else if (w_top_sum > {1'b0, w_limit}) begin
                    n_st = ST_NO_MEM; n_state = S_DONE;
                end else if (w_cnt_g > ENT_C) begin
                    n_st = ST_FULL; n_state = S_DONE;
                end else begin
                    n_wa_v = 1'b1; n_wa_i = r_count[IDX_W-1:0];
                    n_wa = '{seg_start: r_heap_top[ADDR_W-1:0], seg_len: r_rsize, seg_res: 1'b1};
                    n_wb_v = w_split_g; n_wb_i = r_count[IDX_W-1:0] + IDX_W'(1);
                    n_wb = '{seg_start: r_heap_top[ADDR_W-1:0] + r_rsize[ADDR_W-1:0],
                             seg_len: w_grow_amt - r_rsize, seg_res: 1'b0};
                    n_heap_top = w_top_sum[LEN_W-1:0];
                    n_count = w_cnt_g[CNT_W-1:0];
                    n_res_addr = r_heap_top[ADDR_W-1:0];
                    n_state = S_MOD;
                end
                if (r_moving && n_state == S_MOD) begin
                    n_moved = 1'b1;
                    n_old_len = (r_li < r_rsize) ? r_li : r_rsize;
                end
            end
            S_MOD: begin
                n_j = w_last ? '0 : r_j + IDX_W'(1);
                if (w_last) begin
                    n_wa_v = 1'b0; n_wb_v = 1'b0;
                    n_state = S_NEXT;
                end
            end
            S_DROP: begin
                n_j = w_last ? '0 : r_j + IDX_W'(1);
                if (w_last) begin
                    if (r_db_v) begin
                        n_da = r_db; n_db_v = 1'b0;
                    end else begin
                        n_da_v = 1'b0;
                    end
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_da_v) begin
                    n_state = S_DROP;
                end else if (r_ap_v) begin
                    n_wa_v = 1'b1; n_wa_i = r_count[IDX_W-1:0]; n_wa = r_ap;
                    n_count = r_count + CNT_W'(1);
                    n_ap_v = 1'b0;
                    n_state = S_MOD;
                end else if (r_moving && !r_releasing) begin
                    n_releasing = 1'b1;
                    n_fn = 1'b0; n_fp = 1'b0;
                    n_state = S_FIND_NB;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_j <= '0; r_count <= '0; r_heap_top <= '0;
            r_grow <= GROW_RESET; r_pool <= POOL_RESET;
            r_wa_v <= 1'b0; r_wb_v <= 1'b0; r_da_v <= 1'b0; r_db_v <= 1'b0;
            r_ap_v <= 1'b0; r_moving <= 1'b0; r_releasing <= 1'b0;
        end else begin
            r_state <= n_state; r_j <= n_j; r_count <= n_count; r_heap_top <= n_heap_top;
            r_grow <= n_grow; r_pool <= n_pool;
            r_wa_v <= n_wa_v; r_wb_v <= n_wb_v; r_da_v <= n_da_v; r_db_v <= n_db_v;
            r_ap_v <= n_ap_v; r_moving <= n_moving; r_releasing <= n_releasing;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act; r_addr <= n_addr; r_rsize <= n_rsize;
        r_fi <= n_fi; r_ri <= n_ri; r_i <= n_i; r_si <= n_si; r_li <= n_li;
        r_fn <= n_fn; r_rn <= n_rn; r_n <= n_n; r_ln <= n_ln;
        r_fp <= n_fp; r_rp <= n_rp; r_p <= n_p; r_sp <= n_sp; r_lp <= n_lp;
        r_fb <= n_fb; r_b <= n_b; r_sb <= n_sb; r_lb <= n_lb; r_slk <= n_slk;
        r_wa_i <= n_wa_i; r_wa <= n_wa; r_wb_i <= n_wb_i; r_wb <= n_wb;
        r_da <= n_da; r_db <= n_db; r_ap <= n_ap;
        r_st <= n_st; r_res_addr <= n_res_addr; r_moved <= n_moved; r_old_len <= n_old_len;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_cfg_ready      = !busy;
    assign o_done           = (r_state == S_DONE);
    assign o_result_address = r_res_addr;
    assign o_status         = r_st;
    assign o_moved          = r_moved;
    assign o_old_length     = r_old_len;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe outside a transaction");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction not started");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_W'(TABLE_ENTRIES)))
        else $error("segment count beyond table size");

    a_top_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_heap_top <= ADDR_SPAN))
        else $error("heap top beyond address span");

endmodule
